>>> rtl/core/u16u8_pkg.sv
// Shared types, constants and UTF-8 encoding functions for the UTF-16 to UTF-8 transcoder.
// Used by the front, the command queue, the back and the top level.
// Depends on nothing.
package u16u8_pkg;

    // Depth of the command queue between the front and the back.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Surrogate prefixes (upper six bits of a code unit).
    localparam logic [5:0] HIGH_SURR_PREFIX = 6'b110110;
    localparam logic [5:0] LOW_SURR_PREFIX  = 6'b110111;

    // Offset of the supplementary planes.
    localparam logic [20:0] SUPP_BASE = 21'h10000;

    // Lead byte marks and the continuation byte mark.
    localparam logic [7:0] LEAD2 = 8'hC0;
    localparam logic [7:0] LEAD3 = 8'hE0;
    localparam logic [7:0] LEAD4 = 8'hF0;
    localparam logic [7:0] CONT  = 8'h80;

    // One unit of work for the back: an optional held high surrogate that is
    // encoded alone, followed by an optional main code point.
    typedef struct packed {
        logic        has_pre;
        logic [15:0] pre_cp;
        logic        has_main;
        logic [20:0] cp;
        logic        stream_end;
    } u16u8_cmd_t;

    // Index of the last byte of the UTF-8 sequence for a code point.
    function automatic logic [1:0] utf8_last_idx(input logic [20:0] cp);
        logic [1:0] idx;
        if (cp < 21'h80)
        begin
            idx = 2'd0;
        end
        else if (cp < 21'h800)
        begin
            idx = 2'd1;
        end
        else if (cp < SUPP_BASE)
        begin
            idx = 2'd2;
        end
        else
        begin
            idx = 2'd3;
        end
        return idx;
    endfunction

    // Byte number k of the UTF-8 sequence for a code point.
    function automatic logic [7:0] utf8_byte_at(input logic [20:0] cp, input logic [1:0] k);
        logic [7:0] b [4];
        b[0] = 8'h00;
        b[1] = 8'h00;
        b[2] = 8'h00;
        b[3] = 8'h00;
        unique case (utf8_last_idx(cp))
            2'd0:
            begin
                b[0] = {1'b0, cp[6:0]};
            end
            2'd1:
            begin
                b[0] = LEAD2 | {3'b000, cp[10:6]};
                b[1] = CONT | {2'b00, cp[5:0]};
            end
            2'd2:
            begin
                b[0] = LEAD3 | {4'b0000, cp[15:12]};
                b[1] = CONT | {2'b00, cp[11:6]};
                b[2] = CONT | {2'b00, cp[5:0]};
            end
            default:
            begin
                b[0] = LEAD4 | {5'b00000, cp[20:18]};
                b[1] = CONT | {2'b00, cp[17:12]};
                b[2] = CONT | {2'b00, cp[11:6]};
                b[3] = CONT | {2'b00, cp[5:0]};
            end
        endcase
        return b[k];
    endfunction

endpackage

>>> rtl/core/u16u8_front.sv
// Front of the transcoder: accepts code units, pairs surrogates and issues commands.
// Depends on u16u8_pkg.
module u16u8_front import u16u8_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [15:0] code_unit,
    input  logic        stream_end,
    input  logic        q_full,
    output logic        q_push,
    output u16u8_cmd_t  q_cmd
);

    logic        pend_valid_reg;
    logic        pend_valid_next;
    logic [15:0] pend_high_reg;
    logic [15:0] pend_high_next;
    logic        accept;
    logic        is_high;
    logic        is_low;
    logic        pair;
    logic        hold;

    // Classify the incoming unit.
    assign is_high = (code_unit[15:10] == HIGH_SURR_PREFIX);
    assign is_low  = (code_unit[15:10] == LOW_SURR_PREFIX);
    assign pair    = pend_valid_reg && is_low;
    assign hold    = is_high && !stream_end;

    // The front stalls only when the queue has no room.
    assign full   = q_full;
    assign accept = push && !q_full;

    // Build the command for this beat.
    always_comb
    begin
        q_cmd.has_pre    = pend_valid_reg && !is_low;
        q_cmd.pre_cp     = pend_high_reg;
        q_cmd.has_main   = !hold;
        q_cmd.cp         = pair ? (SUPP_BASE + {1'b0, pend_high_reg[9:0], code_unit[9:0]})
                                : {5'd0, code_unit};
        q_cmd.stream_end = stream_end;
    end

    assign q_push = accept && (q_cmd.has_pre || q_cmd.has_main);

    // Held high surrogate.
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_high_next  = pend_high_reg;
        if (accept)
        begin
            pend_valid_next = hold;
            pend_high_next  = hold ? code_unit : 16'h0000;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            pend_high_reg  <= 16'h0000;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            pend_high_reg  <= pend_high_next;
        end
    end

endmodule

>>> rtl/core/u16u8_queue.sv
// Short command queue that decouples the front from the back.
// Depends on u16u8_pkg.
module u16u8_queue import u16u8_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_push,
    input  u16u8_cmd_t q_din,
    output logic       q_full,
    input  logic       q_pop,
    output logic       q_empty,
    output u16u8_cmd_t q_head
);

    u16u8_cmd_t        mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign q_full  = (count_reg == QCNT_W'(QDEPTH));
    assign q_empty = (count_reg == '0);
    assign q_head  = mem[rd_ptr_reg];
    assign do_push = q_push && !q_full;
    assign do_pop  = q_pop && !q_empty;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= q_din;
        end
    end

endmodule

>>> rtl/core/u16u8_back.sv
// Back: turns commands into UTF-8 bytes in an output register, one per cycle while not stalled.
// Depends on u16u8_pkg.
module u16u8_back import u16u8_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_empty,
    input  u16u8_cmd_t q_head,
    output logic       q_pop,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] utf8_byte,
    output logic       run_last,
    output logic       string_last
);

    typedef enum logic {SEG_PRE, SEG_MAIN} seg_t;

    logic        busy_reg;
    logic        busy_next;
    seg_t        seg_reg;
    seg_t        seg_next;
    logic [1:0]  idx_reg;
    logic [1:0]  idx_next;
    u16u8_cmd_t  cmd_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [7:0]  byte_reg;
    logic        run_last_reg;
    logic        string_last_reg;
    logic [20:0] cur_cp;
    logic        out_free;
    logic        step;
    logic        seg_end;
    logic        cmd_done;
    logic        load;

    // Current code point and sequencing conditions.
    assign cur_cp   = (seg_reg == SEG_MAIN) ? cmd_reg.cp : {5'd0, cmd_reg.pre_cp};
    assign out_free = !out_valid_reg || pop;
    assign step     = busy_reg && out_free;
    assign seg_end  = (idx_reg == utf8_last_idx(cur_cp));
    assign cmd_done = seg_end && ((seg_reg == SEG_MAIN) || !cmd_reg.has_main);
    assign load     = (!busy_reg || (step && cmd_done)) && !q_empty;
    assign q_pop    = load;

    // Next state of the byte sequencer and the output register valid.
    always_comb
    begin
        busy_next      = busy_reg;
        seg_next       = seg_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (step)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
        if (load)
        begin
            busy_next = 1'b1;
            seg_next  = q_head.has_pre ? SEG_PRE : SEG_MAIN;
            idx_next  = 2'd0;
        end
        else if (step)
        begin
            if (cmd_done)
            begin
                busy_next = 1'b0;
                idx_next  = 2'd0;
            end
            else if (seg_end)
            begin
                seg_next = SEG_MAIN;
                idx_next = 2'd0;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            seg_reg       <= SEG_PRE;
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            seg_reg       <= seg_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: the command in work and the outgoing beat.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cmd_reg <= q_head;
        end
        if (step)
        begin
            byte_reg        <= utf8_byte_at(cur_cp, idx_reg);
            run_last_reg    <= cmd_done;
            string_last_reg <= cmd_done && cmd_reg.stream_end;
        end
    end

    assign empty       = !out_valid_reg;
    assign utf8_byte   = byte_reg;
    assign run_last    = run_last_reg;
    assign string_last = string_last_reg;

endmodule

>>> rtl/core/utf16_to_utf8_transcoder.sv
// UTF-16 to UTF-8 transcoder: top level joining the front, the command queue and the back.
// Depends on u16u8_pkg, u16u8_front, u16u8_queue and u16u8_back.
//
// Usage:
// The input side is a queue write port: a beat carrying one UTF-16 code unit and its
// stream_end flag is taken on a clock edge where push is high and full is low.
// The result side is a queue read port: while empty is low, the oldest UTF-8 byte is
// on utf8_byte with run_last (last byte caused by its input beat) and string_last
// (final byte of the string); it is taken on an edge where pop is high.
// A high surrogate without stream_end is held and produces no bytes until the next
// unit arrives; the pair then yields four bytes, or the lone surrogate three.
// The first byte of a beat passes through the command queue, the command register of the
// back and the output register before it is visible. Throughput: one output byte per cycle
// while the receiver does not stall, set by the single byte sequencer in the back, so a code
// unit yields zero to six bytes (about three for BMP text beyond Latin); a four-entry command
// queue lets the input keep flowing while the back is busy or the receiver stalls.
// When the receiver stalls, the byte stays on the ports, the back halts, the queue
// fills and full then rises. Reset empties the queue and the output register and
// drops any held surrogate.
module utf16_to_utf8_transcoder import u16u8_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [15:0] code_unit,
    input  logic        stream_end,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  utf8_byte,
    output logic        run_last,
    output logic        string_last
);

    u16u8_cmd_t front_cmd;
    u16u8_cmd_t head_cmd;
    logic       q_push;
    logic       q_full;
    logic       q_pop;
    logic       q_empty;

    // Front: surrogate pairing and command issue.
    u16u8_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .code_unit  (code_unit),
        .stream_end (stream_end),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_cmd      (front_cmd)
    );

    // Command queue between the two halves.
    u16u8_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_push  (q_push),
        .q_din   (front_cmd),
        .q_full  (q_full),
        .q_pop   (q_pop),
        .q_empty (q_empty),
        .q_head  (head_cmd)
    );

    // Back: byte sequencer and output register.
    u16u8_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_head      (head_cmd),
        .q_pop       (q_pop),
        .empty       (empty),
        .pop         (pop),
        .utf8_byte   (utf8_byte),
        .run_last    (run_last),
        .string_last (string_last)
    );

endmodule
